// File: src/pcpa_pkg.sv
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types and codes of the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;

	// request kinds
	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	// register index (paddr[2])
	localparam logic REG_BASE = 1'b0;
	localparam logic REG_TOP  = 1'b1;

	localparam logic [31:0] BASE_RESET = 32'h8000_0000;
	localparam logic [31:0] TOP_RESET  = 32'h8800_0000;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_POP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture request
		logic free_eval;   // check and push a free, emit result
		logic alloc_read;  // latch selected list, read its head link
		logic alloc_none;  // emit "no page left"
		logic alloc_pop;   // pop the head, emit grant
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_free;
		logic found;
		logic out_free;
	} sts_t;

endpackage

// File: src/pcpa_ram.sv
// ----------------------------------------------------------------------------
// pcpa_ram
// Generic single-port RAM, registered read, no reset.
// ----------------------------------------------------------------------------
module pcpa_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// File: src/pcpa_ctrl.sv
// ----------------------------------------------------------------------------
// pcpa_ctrl
// Request sequencer: accept, evaluate, and pop the link read for allocates.
// ----------------------------------------------------------------------------
module pcpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pcpa_pkg::sts_t sts,
	output pcpa_pkg::cmd_t cmd
);

	pcpa_pkg::state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcpa_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			pcpa_pkg::S_IDLE: begin
				if (in_valid) state_n = pcpa_pkg::S_EVAL;
			end
			pcpa_pkg::S_EVAL: begin
				if (sts.is_free) begin
					if (sts.out_free) state_n = pcpa_pkg::S_IDLE;
				end else if (sts.found) begin
					state_n = pcpa_pkg::S_POP;
				end else if (sts.out_free) begin
					state_n = pcpa_pkg::S_IDLE;
				end
			end
			pcpa_pkg::S_POP: begin
				if (sts.out_free) state_n = pcpa_pkg::S_IDLE;
			end
			default: state_n = pcpa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pcpa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			pcpa_pkg::S_EVAL: begin
				cmd.free_eval  = sts.is_free && sts.out_free;
				cmd.alloc_read = !sts.is_free && sts.found;
				cmd.alloc_none = !sts.is_free && !sts.found && sts.out_free;
			end
			pcpa_pkg::S_POP: begin
				cmd.alloc_pop = sts.out_free;
			end
			default: ;
		endcase
	end

	// a pop only follows a link read
	a_pop_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcpa_pkg::S_POP) |->
		($past(state_q) == pcpa_pkg::S_EVAL || $past(state_q) == pcpa_pkg::S_POP))
		else $error("pop state entered without link read");

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == pcpa_pkg::S_EVAL))
		else $error("accepted request not evaluated");

	// nothing is emitted into an occupied output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.free_eval || cmd.alloc_none || cmd.alloc_pop) |-> sts.out_free)
		else $error("result emitted while output busy");

endmodule

// File: src/pcpa_dp.sv
// ----------------------------------------------------------------------------
// pcpa_dp
// Datapath: request registers, list heads, link store, result register.
// ----------------------------------------------------------------------------
module pcpa_dp #(
	parameter int CPU_COUNT  = 8,
	parameter int POOL_PAGES = 32768,
	parameter int PAGE_BYTES = 4096,
	localparam int LOG_PB    = $clog2(PAGE_BYTES),
	localparam int BPW       = 33 - LOG_PB
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pcpa_pkg::cmd_t  cmd,
	output pcpa_pkg::sts_t  sts,
	input  logic            in_func,
	input  logic [2:0]      in_cpu_id,
	input  logic [31:0]     in_page_address,
	input  logic [31:0]     base_address,
	input  logic [31:0]     top_address,
	input  logic [BPW-1:0]  base_page,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      out_status,
	output logic [31:0]     out_granted_address,
	output logic            out_stolen
);

	localparam int PW   = $clog2(POOL_PAGES);
	localparam int CW   = $clog2(CPU_COUNT);
	localparam int SUMW = BPW + 1;

	logic        func_q;
	logic [2:0]  cpu_q;
	logic [31:0] addr_q;

	logic [PW-1:0] head_q [CPU_COUNT];
	logic [CPU_COUNT-1:0] hv_q;
	logic [CW-1:0] sel_q;
	logic          steal_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [31:0] granted_q;
	logic        stolen_q;

	logic          out_free;
	logic [CPU_COUNT-1:0] match;
	logic [PW-1:0] own_head;
	logic          own_hv;
	logic [CW-1:0] own_idx;
	logic          found;
	logic [CW-1:0] sel_n;
	logic          steal_n;

	logic [BPW-1:0] diff;
	logic           free_ok;
	logic [PW-1:0]  pidx;

	logic             ram_en;
	logic             ram_we;
	logic [PW-1:0]    ram_addr;
	logic [PW:0]      ram_wdata;
	logic [PW:0]      ram_rdata;

	logic [SUMW-1:0]        gsum;
	logic [SUMW+LOG_PB-1:0] gfull;

	assign out_free = !out_valid_q || out_ready;

	// requester's own list
	always_comb begin
		own_head = '0;
		own_hv   = 1'b0;
		own_idx  = '0;
		for (int c = 0; c < CPU_COUNT; c++) begin
			match[c] = ({2'b0, cpu_q} == 5'(c));
			if (match[c]) begin
				own_head = head_q[c];
				own_hv   = hv_q[c];
				own_idx  = CW'(c);
			end
		end
	end

	// own list first, else lowest-numbered non-empty other list
	always_comb begin
		found   = 1'b0;
		sel_n   = '0;
		steal_n = 1'b0;
		if (own_hv) begin
			found = 1'b1;
			sel_n = own_idx;
		end else begin
			for (int c = 0; c < CPU_COUNT; c++) begin
				if (!found && hv_q[c] && !match[c]) begin
					found   = 1'b1;
					sel_n   = CW'(c);
					steal_n = 1'b1;
				end
			end
		end
	end

	// free address check; diff only meaningful once aligned and >= base
	assign diff = BPW'(addr_q[31:LOG_PB]) - base_page;
	assign pidx = diff[PW-1:0];
	assign free_ok = ({2'b0, cpu_q} < 5'(CPU_COUNT))
		&& (addr_q[LOG_PB-1:0] == '0)
		&& (addr_q >= base_address)
		&& (addr_q < top_address)
		&& ({1'b0, diff} < (BPW+1)'(POOL_PAGES));

	assign ram_we    = cmd.free_eval && free_ok;
	assign ram_en    = ram_we || cmd.alloc_read;
	assign ram_addr  = cmd.free_eval ? pidx : head_q[sel_n];
	assign ram_wdata = {own_hv, own_head};

	pcpa_ram #(
		.WIDTH (PW + 1),
		.DEPTH (POOL_PAGES)
	) u_link (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign gsum  = SUMW'(base_page) + SUMW'(head_q[sel_q]);
	assign gfull = {gsum, {LOG_PB{1'b0}}};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			cpu_q  <= in_cpu_id;
			addr_q <= in_page_address;
		end
		if (cmd.alloc_read) begin
			sel_q   <= sel_n;
			steal_q <= steal_n;
		end
		if (ram_we) begin
			for (int c = 0; c < CPU_COUNT; c++) begin
				if (match[c]) head_q[c] <= pidx;
			end
		end
		if (cmd.alloc_pop) begin
			head_q[sel_q] <= ram_rdata[PW-1:0];
		end
		if (cmd.free_eval) begin
			status_q  <= free_ok ? pcpa_pkg::ST_DONE : pcpa_pkg::ST_BAD;
			granted_q <= '0;
			stolen_q  <= 1'b0;
		end else if (cmd.alloc_none) begin
			status_q  <= pcpa_pkg::ST_EMPTY;
			granted_q <= '0;
			stolen_q  <= 1'b0;
		end else if (cmd.alloc_pop) begin
			status_q  <= pcpa_pkg::ST_DONE;
			granted_q <= gfull[31:0];
			stolen_q  <= steal_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				hv_q <= hv_q | match;
			end
			if (cmd.alloc_pop) begin
				hv_q[sel_q] <= ram_rdata[PW];
			end
			if (cmd.free_eval || cmd.alloc_none || cmd.alloc_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts = '{
		is_free:  (func_q == pcpa_pkg::FN_FREE),
		found:    found,
		out_free: out_free
	};

	assign out_valid           = out_valid_q;
	assign out_status          = status_q;
	assign out_granted_address = granted_q;
	assign out_stolen          = stolen_q;

endmodule

// File: src/per_cpu_page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// Page allocator with one LIFO free list per CPU and cross-CPU stealing.
// ----------------------------------------------------------------------------
// One request is in flight at a time. A free is accepted, then checked and
// pushed; an allocate is accepted, then does list select and link read, then
// pops, as the single-port link memory has a registered read. Results sit in
// an output register, so a new request is accepted while the last result
// still waits. Lists start empty after reset and are filled by frees; the
// link memory needs no clearing pass. The user must write pool base and top
// over APB (base at 0x0, top at 0x4) only while idle; the block won't check.
module per_cpu_page_free_list_allocator #(
	parameter int CPU_COUNT  = 8,
	parameter int POOL_PAGES = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] page_address
	input  logic [3:0]  s_tuser,   // [0] func, [3:1] cpu_id
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] granted_address
	output logic [2:0]  m_tuser,   // [1:0] status, [2] stolen
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int LOG_PB = $clog2(PAGE_BYTES);
	localparam int BPW    = 33 - LOG_PB;
	localparam logic [32:0] BASE_RST_SUM =
		{1'b0, pcpa_pkg::BASE_RESET} + 33'(PAGE_BYTES - 1);

	logic [31:0]    base_q;
	logic [31:0]    top_q;
	logic [BPW-1:0] base_page_q;
	logic [32:0]    base_sum;
	logic           cfg_wr;
	logic [1:0]     res_status;
	logic           res_stolen;

	pcpa_pkg::cmd_t cmd;
	pcpa_pkg::sts_t sts;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign base_sum = {1'b0, pwdata} + 33'(PAGE_BYTES - 1);
	assign m_tuser  = {res_stolen, res_status};

	// first pool page number kept ready alongside the base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= pcpa_pkg::BASE_RESET;
			top_q       <= pcpa_pkg::TOP_RESET;
			base_page_q <= BASE_RST_SUM[32:LOG_PB];
		end else if (cfg_wr) begin
			unique case (paddr[2])
				pcpa_pkg::REG_BASE: begin
					base_q      <= pwdata;
					base_page_q <= base_sum[32:LOG_PB];
				end
				pcpa_pkg::REG_TOP: top_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			pcpa_pkg::REG_BASE: prdata = base_q;
			pcpa_pkg::REG_TOP:  prdata = top_q;
			default:            prdata = '0;
		endcase
	end

	pcpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcpa_dp #(
		.CPU_COUNT  (CPU_COUNT),
		.POOL_PAGES (POOL_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.in_func             (s_tuser[0]),
		.in_cpu_id           (s_tuser[3:1]),
		.in_page_address     (s_tdata),
		.base_address        (base_q),
		.top_address         (top_q),
		.base_page           (base_page_q),
		.out_valid           (m_tvalid),
		.out_ready           (m_tready),
		.out_status          (res_status),
		.out_granted_address (m_tdata),
		.out_stolen          (res_stolen)
	);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-CPU page free-list allocator. A directed
// table covers reset state, address rejects, LIFO order and stealing; then
// random free/allocate traffic runs under several pool base/top settings,
// with random stalls on both stream sides. Every result is checked against
// its row's own expected outcome where the table gives one, else a local model of the per-CPU lists and the link store.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CPU_N       = 8;
	localparam int POOL_N      = 32768;
	localparam int PAGE_SZ     = 4096;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] granted;
		logic        stolen;
	} outcome_t;

	typedef struct packed {
		logic        func;
		logic [2:0]  cpu;
		logic [31:0] addr;
		logic        typed;  // row carries its own expected outcome
		outcome_t    want;
	} dir_row_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] top;
		int          alloc_pct;
		logic        quiet;  // no idling on either side
		int          count;
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] page_address
	logic [3:0]  s_tuser;   // [0] func, [3:1] cpu_id
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] granted_address
	logic [2:0]  m_tuser;   // [1:0] status, [2] stolen
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	per_cpu_page_free_list_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// local copy of the allocator state
	logic [31:0] pool_base;
	logic [31:0] pool_top;
	logic [14:0] head_idx [CPU_N];
	bit          head_ok  [CPU_N];
	logic [14:0] link_idx [POOL_N];
	bit          link_ok  [POOL_N];

	outcome_t outcomes [$];
	outcome_t want;
	bit       steady;
	int       errors;
	int       cycle_cnt;
	int       n_sent, n_pushed, n_rejected, n_granted, n_stolen, n_empty, n_settings;

	function automatic longint unsigned first_page();
		return (longint'(pool_base) + PAGE_SZ - 1) / PAGE_SZ;
	endfunction

	function automatic logic [14:0] take_head(int c);
		logic [14:0] pg;
		pg = head_idx[c];
		head_idx[c] = link_idx[pg];
		head_ok[c] = link_ok[pg];
		return pg;
	endfunction

	function automatic outcome_t predict_page_op(logic func, logic [2:0] cpu, logic [31:0] addr);
		outcome_t        o;
		longint unsigned a, bp, pidx;
		logic [14:0]     pg;
		bit              got;
		o = '{pcpa_pkg::ST_DONE, 32'd0, 1'b0};
		a = addr;
		bp = first_page();
		got = 0;
		pg = '0;
		// cpu_id is 3 bits wide, so it never exceeds the CPU count here
		if (func == pcpa_pkg::FN_FREE) begin
			pidx = a / PAGE_SZ - bp;
			if (a % PAGE_SZ == 0 && a >= pool_base && a < pool_top && pidx < POOL_N) begin
				pg = pidx[14:0];
				link_idx[pg] = head_idx[cpu];
				link_ok[pg] = head_ok[cpu];
				head_idx[cpu] = pg;
				head_ok[cpu] = 1;
				n_pushed++;
			end else begin
				o.status = pcpa_pkg::ST_BAD;
				n_rejected++;
			end
		end else begin
			if (head_ok[cpu]) begin
				pg = take_head(cpu);
				got = 1;
			end else begin
				for (int c = 0; c < CPU_N; c++)
					if (!got && c != cpu && head_ok[c]) begin
						pg = take_head(c);
						got = 1;
						o.stolen = 1'b1;
					end
			end
			if (got) begin
				o.granted = 32'((bp + pg) * PAGE_SZ);
				n_granted++;
				if (o.stolen) n_stolen++;
			end else begin
				o.status = pcpa_pkg::ST_EMPTY;
				n_empty++;
			end
		end
		return o;
	endfunction

	// well-formed: an aligned page inside the pool, mostly low pages for reuse
	function automatic logic [31:0] pick_free_addr(bit well_formed);
		longint unsigned bp, lim, span, idx;
		bp = first_page();
		lim = (longint'(pool_top) + PAGE_SZ - 1) / PAGE_SZ;
		span = (lim > bp) ? lim - bp : 0;
		if (span > POOL_N) span = POOL_N;
		if (well_formed && span > 0) begin
			if ($urandom_range(0, 9) < 7)
				idx = $urandom_range(0, int'((span < 64) ? span - 1 : 63));
			else
				idx = $urandom % span;
			return 32'((bp + idx) * PAGE_SZ);
		end
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'(bp * PAGE_SZ) + $urandom_range(1, PAGE_SZ - 1);
			2: return pool_top & ~32'(PAGE_SZ - 1);
			3: return pool_base - PAGE_SZ;
			default: return 32'((bp + POOL_N) * PAGE_SZ);
		endcase
	endfunction

	task automatic send_req(logic func, logic [2:0] cpu, logic [31:0] addr, bit typed,
	                        outcome_t typed_want);
		int       gap;
		outcome_t pred;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= addr;
		s_tuser <= {cpu, func};
		pred = predict_page_op(func, cpu, addr);
		outcomes.push_back(typed ? typed_want : pred);
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		n_sent++;
	endtask

	task automatic drain();
		while (outcomes.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// write a register, then read it back
	task automatic reg_write(logic sel, logic [31:0] val);
		logic [31:0] rd;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {sel, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		if (sel == pcpa_pkg::REG_BASE) pool_base = val;
		else pool_top = val;
		if (rd !== val) begin
			$display("%0t: reg %0d readback expected %h got %h", $time, sel, val, rd);
			errors++;
		end
	endtask

	dir_row_t dir_rows [22] = '{
		'{pcpa_pkg::FN_ALLOC, 3'd0, 32'h0000_0000, 1'b1, '{pcpa_pkg::ST_EMPTY, 32'd0, 1'b0}},
		'{pcpa_pkg::FN_FREE,  3'd0, 32'h8000_0001, 1'b1, '{pcpa_pkg::ST_BAD,   32'd0, 1'b0}},
		'{pcpa_pkg::FN_FREE,  3'd1, 32'h8000_0800, 1'b1, '{pcpa_pkg::ST_BAD,   32'd0, 1'b0}},
		'{pcpa_pkg::FN_FREE,  3'd2, 32'h7FFF_F000, 1'b1, '{pcpa_pkg::ST_BAD,   32'd0, 1'b0}},
		'{pcpa_pkg::FN_FREE,  3'd3, 32'h8800_0000, 1'b1, '{pcpa_pkg::ST_BAD,   32'd0, 1'b0}},
		'{pcpa_pkg::FN_FREE,  3'd4, 32'hFFFF_FFFF, 1'b1, '{pcpa_pkg::ST_BAD,   32'd0, 1'b0}},
		'{pcpa_pkg::FN_FREE,  3'd5, 32'h0000_0000, 1'b1, '{pcpa_pkg::ST_BAD,   32'd0, 1'b0}},
		'{pcpa_pkg::FN_FREE,  3'd0, 32'h8000_0000, 1'b1, '{pcpa_pkg::ST_DONE,  32'd0, 1'b0}},
		'{pcpa_pkg::FN_FREE,  3'd7, 32'h87FF_F000, 1'b1, '{pcpa_pkg::ST_DONE,  32'd0, 1'b0}},
		'{pcpa_pkg::FN_FREE,  3'd0, 32'h8000_1000, 1'b0, '0},
		'{pcpa_pkg::FN_ALLOC, 3'd0, 32'hFFFF_FFFF, 1'b0, '0},
		'{pcpa_pkg::FN_ALLOC, 3'd0, 32'h0000_0000, 1'b0, '0},
		'{pcpa_pkg::FN_ALLOC, 3'd0, 32'h1234_5678, 1'b0, '0},  // steals the top page from cpu 7
		'{pcpa_pkg::FN_ALLOC, 3'd7, 32'h0000_0000, 1'b1, '{pcpa_pkg::ST_EMPTY, 32'd0, 1'b0}},
		'{pcpa_pkg::FN_FREE,  3'd6, 32'h8000_5000, 1'b0, '0},
		'{pcpa_pkg::FN_FREE,  3'd6, 32'h8000_6000, 1'b0, '0},
		'{pcpa_pkg::FN_FREE,  3'd2, 32'h8000_7000, 1'b0, '0},
		'{pcpa_pkg::FN_ALLOC, 3'd1, 32'h0000_0000, 1'b0, '0},  // lowest non-empty cpu wins
		'{pcpa_pkg::FN_ALLOC, 3'd6, 32'h0000_0000, 1'b0, '0},
		'{pcpa_pkg::FN_ALLOC, 3'd3, 32'h0000_0000, 1'b0, '0},
		'{pcpa_pkg::FN_FREE,  3'd3, 32'h8000_2000, 1'b0, '0},
		'{pcpa_pkg::FN_FREE,  3'd4, 32'h8000_3000, 1'b0, '0}   // left listed across base changes
	};

	// lists carry over between settings, so grants get recomputed from new bases
	phase_t phases [7] = '{
		'{pcpa_pkg::BASE_RESET, pcpa_pkg::TOP_RESET, 40, 1'b0, 250},
		'{32'h0000_0000, 32'hFFFF_FFFF, 50, 1'b1, 250},
		'{32'h1000_0800, 32'h1001_0000, 55, 1'b0, 200},
		'{32'hFFFF_F000, 32'hFFFF_FFFF, 50, 1'b0, 100},
		'{32'hFFFF_FFFF, 32'h0000_0000, 70, 1'b0, 150},
		'{32'h0000_1000, 32'h0002_1000, 45, 1'b0, 250},
		'{pcpa_pkg::BASE_RESET, pcpa_pkg::TOP_RESET, 50, 1'b1, 200}
	};

	// stream sink with random stalls
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			stall = steady ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (outcomes.size() == 0) begin
				$display("%0t: result with none pending: status %0d addr %h stolen %0d",
				         $time, m_tuser[1:0], m_tdata, m_tuser[2]);
				errors++;
			end else begin
				want = outcomes.pop_front();
				if (m_tuser[1:0] !== want.status || m_tdata !== want.granted ||
				    m_tuser[2] !== want.stolen) begin
					$display("%0t: expected status %0d addr %h stolen %0d, got %0d %h %0d",
					         $time, want.status, want.granted, want.stolen,
					         m_tuser[1:0], m_tdata, m_tuser[2]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results pending", $time, outcomes.size());
			$display("[per_cpu_page_free_list_allocator] ERROR");
			$finish;
		end
	end

	initial begin
		int          r;
		logic        func;
		logic [2:0]  cpu;
		logic [31:0] addr;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		steady = 0;
		errors = 0;
		cycle_cnt = 0;
		pool_base = pcpa_pkg::BASE_RESET;
		pool_top = pcpa_pkg::TOP_RESET;
		for (int c = 0; c < CPU_N; c++) begin
			head_idx[c] = '0;
			head_ok[c] = 0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i].func, dir_rows[i].cpu, dir_rows[i].addr,
			         dir_rows[i].typed, dir_rows[i].want);

		foreach (phases[p]) begin
			s_tvalid <= 1'b0;
			drain();
			reg_write(pcpa_pkg::REG_BASE, phases[p].base);
			reg_write(pcpa_pkg::REG_TOP, phases[p].top);
			n_settings++;
			steady = phases[p].quiet;
			for (int k = 0; k < phases[p].count; k++) begin
				r = $urandom_range(0, 99);
				cpu = $urandom_range(0, CPU_N - 1);
				if (r < phases[p].alloc_pct) begin
					func = pcpa_pkg::FN_ALLOC;
					addr = $urandom;
				end else begin
					func = pcpa_pkg::FN_FREE;
					addr = pick_free_addr(r < phases[p].alloc_pct +
					                      (100 - phases[p].alloc_pct) * 4 / 5);
				end
				send_req(func, cpu, addr, 0, '0);
			end
		end
		s_tvalid <= 1'b0;
		steady = 0;
		drain();
		repeat (10) @(posedge clk);

		$display("covered %0d requests over %0d pool settings: %0d pushes, %0d rejects",
		         n_sent, n_settings, n_pushed, n_rejected);
		$display("grants %0d (stolen %0d), empty %0d", n_granted, n_stolen, n_empty);
		if (errors == 0) begin
			$display("[per_cpu_page_free_list_allocator] OK");
		end else begin
			$display("[per_cpu_page_free_list_allocator] ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
src/pcpa_pkg.sv
src/pcpa_ram.sv
src/pcpa_ctrl.sv
src/pcpa_dp.sv
src/per_cpu_page_free_list_allocator.sv
tb/tb_top.sv
